[rtl/mpcq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mpcq_pkg
// types, codes and reset constants shared by the mouse packet cursor queue
// ----------------------------------------------------------------------------
package mpcq_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 16;
   localparam int COORD_BITS_DEFAULT  = 12;
   localparam int SIZE_BITS           = 13;

   localparam logic [SIZE_BITS-1:0] HRES_RESET = 13'd800;
   localparam logic [SIZE_BITS-1:0] VRES_RESET = 13'd600;

   // button bits of the status byte
   localparam logic [2:0] BTN_LEFT   = 3'h1;
   localparam logic [2:0] BTN_RIGHT  = 3'h2;
   localparam logic [2:0] BTN_MIDDLE = 3'h4;

   typedef enum logic [1:0] {
      CMD_PACKET = 2'd0,
      CMD_POP    = 2'd1,
      CMD_FLUSH  = 2'd2,
      CMD_SET    = 2'd3
   } cmd_type;

   localparam logic [1:0] CSR_HRES = 2'd0;
   localparam logic [1:0] CSR_VRES = 2'd1;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_READ = 1'b1
   } state_type;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [7:0]         status_byte;
      logic [7:0]         x_byte;
      logic [7:0]         y_byte;
      logic [31:0]        tick_time;
      logic signed [31:0] new_x;
      logic signed [31:0] new_y;
   } req_type;

   typedef struct packed {
      logic               valid_res;
      logic               dropped;
      logic [11:0]        x_pos;
      logic [11:0]        y_pos;
      logic signed [7:0]  dx;
      logic signed [7:0]  dy;
      logic               left;
      logic               right;
      logic               middle;
      logic [31:0]        stamp;
      logic [4:0]         event_count;
   } rsp_type;

   // control from the sequencer to the cursor unit
   typedef struct packed {
      logic update;
      logic set_abs;
   } cursor_ctl_type;

endpackage
`default_nettype wire

[rtl/mpcq_event_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mpcq_event_ram
// event store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module mpcq_event_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 75
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[rtl/mpcq_cursor.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mpcq_cursor
// cursor position registers with relative and absolute update and clamping
// ----------------------------------------------------------------------------
module mpcq_cursor #(
   parameter int COORD_BITS = 12
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire mpcq_pkg::cursor_ctl_type       ctl,
   input  wire logic signed [7:0]              dx,
   input  wire logic signed [7:0]              dy,
   input  wire logic signed [31:0]             new_x,
   input  wire logic signed [31:0]             new_y,
   input  wire logic [mpcq_pkg::SIZE_BITS-1:0] hres,
   input  wire logic [mpcq_pkg::SIZE_BITS-1:0] vres,
   output logic      [COORD_BITS-1:0]          cur_x,
   output logic      [COORD_BITS-1:0]          cur_y,
   output logic      [COORD_BITS-1:0]          next_x,
   output logic      [COORD_BITS-1:0]          next_y
);

   import mpcq_pkg::*;

   localparam int VW = 34;
   localparam int LW = 18;
   localparam logic [LW-1:0] CAP = LW'(1) << COORD_BITS;

   logic [COORD_BITS-1:0] pos_x_ff, pos_x_in;
   logic [COORD_BITS-1:0] pos_y_ff, pos_y_in;
   logic signed [VW-1:0]  vx, vy;

   function automatic logic [COORD_BITS-1:0] clamp_axis(
      input logic signed [VW-1:0] v,
      input logic [SIZE_BITS-1:0] size
   );
      logic [LW-1:0]        s;
      logic signed [VW-1:0] lim;
      logic [COORD_BITS-1:0] r;
      s = LW'(size);
      if (s == '0) s = LW'(1);
      if (s > CAP) s = CAP;
      lim = VW'(s);
      lim = lim - VW'(1);
      if (v < 0) r = '0;
      else if (v > lim) r = lim[COORD_BITS-1:0];
      else r = v[COORD_BITS-1:0];
      return r;
   endfunction

   always_comb begin
      if (ctl.set_abs) begin
         vx = VW'(new_x);
         vy = VW'(new_y);
      end else begin
         vx = VW'($signed({1'b0, pos_x_ff})) + VW'(dx);
         vy = VW'($signed({1'b0, pos_y_ff})) + VW'(dy);
      end
      next_x = clamp_axis(vx, hres);
      next_y = clamp_axis(vy, vres);
      pos_x_in = ctl.update ? next_x : pos_x_ff;
      pos_y_in = ctl.update ? next_y : pos_y_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= '0;
         pos_y_ff <= '0;
      end else begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
      end
   end

   assign cur_x = pos_x_ff;
   assign cur_y = pos_y_ff;

endmodule
`default_nettype wire

[rtl/mouse_packet_cursor_queue_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mouse_packet_cursor_queue_core
// mouse packet decoder with clamped cursor tracking and an event queue
// ----------------------------------------------------------------------------
// Each request carries one command: a decoded three-byte mouse packet, a pop
// of the oldest queued event, a queue flush, or an absolute cursor set. Every
// request gives exactly one response. Packet, flush, set cursor and a pop on
// an empty queue are answered directly: the response is loaded into the
// output register at the accepting edge. A pop of a queued event passes
// through the registered read port of the event memory and then the output
// register; in the read state no request is taken. A new request is taken
// while a response still waits, as long as the output register is freed in
// the same cycle. Events live in one memory of QUEUE_DEPTH entries that needs
// no clearing pass after reset; a packet into a full queue drops the oldest
// event. Screen size is written through the csr port, which is always ready.
// ----------------------------------------------------------------------------
module mouse_packet_cursor_queue_core #(
   parameter int QUEUE_DEPTH = mpcq_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int COORD_BITS  = mpcq_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire mpcq_pkg::req_type              req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output mpcq_pkg::rsp_type                   rsp_data,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [1:0]                     csr_index,
   input  wire logic [mpcq_pkg::SIZE_BITS-1:0] csr_wdata
);

   import mpcq_pkg::*;

   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   // memory word: {time, buttons, dy byte, dx byte, y, x}
   localparam int POS_LO = 0;
   localparam int MOT_LO = 2 * COORD_BITS;
   localparam int TIM_LO = MOT_LO + 19;
   localparam int WORD_W = TIM_LO + 32;

   // screen size registers
   logic [SIZE_BITS-1:0] width_ff, width_in;
   logic [SIZE_BITS-1:0] height_ff, height_in;

   // queue pointers and sequencer
   logic [IW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   state_type     state_ff, state_in;

   // output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    rsp_load;

   // cursor unit
   cursor_ctl_type        cursor_ctl;
   logic signed [7:0]     pkt_dx, pkt_dy;
   logic [7:0]            dy_byte;
   logic [COORD_BITS-1:0] cur_x, cur_y, next_x, next_y;

   // event memory
   logic              wr_en, rd_en;
   logic [IW-1:0]     wr_addr;
   logic [WORD_W-1:0] wr_data, rd_data;

   // queue arithmetic
   logic          accept, out_free, full;
   logic [IW-1:0] head_adj;
   logic [CW-1:0] count_adj;
   logic [CW:0]   slot_sum;
   logic [2:0]    rd_btn;

   function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] p);
      logic [IW-1:0] r;
      if (p == IW'(QUEUE_DEPTH - 1)) r = '0;
      else r = p + IW'(1);
      return r;
   endfunction

   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_HRES: width_in  = csr_wdata;
            CSR_VRES: height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // packet decode: y is negated in 8 bits, so -128 stays -128
   assign dy_byte = 8'(8'd0 - req_data.y_byte);
   assign pkt_dx  = $signed(req_data.x_byte);
   assign pkt_dy  = $signed(dy_byte);

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;

   // a push into a full queue first retires the oldest entry
   assign full      = (count_ff == CW'(QUEUE_DEPTH));
   assign head_adj  = full ? wrap_inc(head_ff) : head_ff;
   assign count_adj = full ? CW'(QUEUE_DEPTH - 1) : count_ff;
   assign slot_sum  = (CW+1)'(head_adj) + (CW+1)'(count_adj);
   assign wr_addr   = (slot_sum >= (CW+1)'(QUEUE_DEPTH))
                      ? IW'(slot_sum - (CW+1)'(QUEUE_DEPTH)) : IW'(slot_sum);

   assign wr_data = {req_data.tick_time, req_data.status_byte[2:0], dy_byte,
                     req_data.x_byte, next_y, next_x};

   assign rd_btn = rd_data[MOT_LO+16 +: 3];

   always_comb begin
      state_in        = state_ff;
      head_in         = head_ff;
      count_in        = count_ff;
      cursor_ctl      = '0;
      wr_en           = 1'b0;
      rd_en           = 1'b0;
      rsp_load        = 1'b0;
      rsp_data_in     = '0;
      rsp_data_in.valid_res   = 1'b1;
      rsp_data_in.x_pos       = 12'(cur_x);
      rsp_data_in.y_pos       = 12'(cur_y);
      rsp_data_in.event_count = 5'(count_ff);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (cmd_type'(req_data.cmd))
                  CMD_PACKET: begin
                     cursor_ctl.update = 1'b1;
                     wr_en    = 1'b1;
                     head_in  = head_adj;
                     count_in = count_adj + CW'(1);
                     rsp_load = 1'b1;
                     rsp_data_in.dropped     = full;
                     rsp_data_in.x_pos       = 12'(next_x);
                     rsp_data_in.y_pos       = 12'(next_y);
                     rsp_data_in.event_count = 5'(count_adj + CW'(1));
                  end
                  CMD_POP: begin
                     if (count_ff == '0) begin
                        rsp_load = 1'b1;
                        rsp_data_in.valid_res = 1'b0;
                     end else begin
                        // read the head entry, answer when the data returns
                        rd_en    = 1'b1;
                        head_in  = wrap_inc(head_ff);
                        count_in = count_ff - CW'(1);
                        state_in = ST_READ;
                     end
                  end
                  CMD_FLUSH: begin
                     head_in  = '0;
                     count_in = '0;
                     rsp_load = 1'b1;
                     rsp_data_in.event_count = '0;
                  end
                  CMD_SET: begin
                     cursor_ctl.update  = 1'b1;
                     cursor_ctl.set_abs = 1'b1;
                     rsp_load = 1'b1;
                     rsp_data_in.x_pos = 12'(next_x);
                     rsp_data_in.y_pos = 12'(next_y);
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            // read data register holds until the output side frees up
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
               rsp_data_in.x_pos  = 12'(rd_data[POS_LO +: COORD_BITS]);
               rsp_data_in.y_pos  = 12'(rd_data[POS_LO+COORD_BITS +: COORD_BITS]);
               rsp_data_in.dx     = $signed(rd_data[MOT_LO +: 8]);
               rsp_data_in.dy     = $signed(rd_data[MOT_LO+8 +: 8]);
               rsp_data_in.left   = |(rd_btn & BTN_LEFT);
               rsp_data_in.right  = |(rd_btn & BTN_RIGHT);
               rsp_data_in.middle = |(rd_btn & BTN_MIDDLE);
               rsp_data_in.stamp  = rd_data[TIM_LO +: 32];
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         width_ff     <= HRES_RESET;
         height_ff    <= VRES_RESET;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   mpcq_cursor #(
      .COORD_BITS (COORD_BITS)
   ) u_cursor (
      .clock  (clock),
      .reset  (reset),
      .ctl    (cursor_ctl),
      .dx     (pkt_dx),
      .dy     (pkt_dy),
      .new_x  (req_data.new_x),
      .new_y  (req_data.new_y),
      .hres   (width_ff),
      .vres   (height_ff),
      .cur_x  (cur_x),
      .cur_y  (cur_y),
      .next_x (next_x),
      .next_y (next_y)
   );

   mpcq_event_ram #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (WORD_W)
   ) u_event_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

endmodule
`default_nettype wire
